// ===== hw/rtl/gdcr_pkg.sv =====
// Shared types, constants and codes for the grid DDA column ray caster.
package gdcr_pkg;

	localparam int MAP_CELLS    = 4096;
	localparam int MAX_COLUMNS  = 1024;
	localparam int NUM_TEXTURES = 10;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QW           = $clog2(QUEUE_DEPTH);
	localparam int DIV_NW       = 25;
	localparam int DIV_DW       = 34;

	localparam logic [24:0] DELTA_INF = 25'h1000000;
	localparam logic [24:0] RECIP_NUM = 25'h0400000;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_CAST  = 2'd2;

	localparam logic [2:0] CFG_SCREEN_W = 3'd0;
	localparam logic [2:0] CFG_SCREEN_H = 3'd1;
	localparam logic [2:0] CFG_MAP_W    = 3'd2;
	localparam logic [2:0] CFG_MAP_H    = 3'd3;
	localparam logic [2:0] CFG_TEX_W    = 3'd4;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [9:0]         column;
		logic [13:0]        pos_x;
		logic [13:0]        pos_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [11:0]        cell_index;
		logic [3:0]         cell_value;
	} req_t;

	typedef struct packed {
		logic               drawn;
		logic [9:0]         out_column;
		logic signed [15:0] draw_start;
		logic [15:0]        line_height;
		logic [3:0]         tex_index;
		logic [7:0]         tex_column;
		logic [15:0]        wall_distance;
		logic               hit_side;
	} rsp_t;

	typedef struct packed {
		logic [10:0] screen_width;
		logic [10:0] screen_height;
		logic [6:0]  map_width;
		logic [6:0]  map_height;
		logic [8:0]  tex_width;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_CLEAR,
		OP_CAST
	} op_t;

	typedef struct packed {
		op_t  op;
		logic col_ok;
		req_t req;
	} work_t;

	typedef enum logic [4:0] {
		BS_INIT,
		BS_IDLE,
		BS_CLEAR,
		BS_CAM,
		BS_RAY,
		BS_DXS,
		BS_DX,
		BS_DYS,
		BS_DY,
		BS_SIDE,
		BS_STEP,
		BS_ADDR,
		BS_READ,
		BS_CHECK,
		BS_CMP,
		BS_LH,
		BS_TEX1,
		BS_TEX2,
		BS_OUT
	} back_state_t;

endpackage

// ===== hw/rtl/gdcr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module gdcr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gdcr_pkg::DIV_NW-1:0]   num,
	input  logic [gdcr_pkg::DIV_DW-1:0]   den,
	output logic                          done,
	output logic [gdcr_pkg::DIV_NW-1:0]   quo
);

	localparam int CW = $clog2(gdcr_pkg::DIV_NW + 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CW-1:0]                 cnt_q;
	logic [gdcr_pkg::DIV_DW-1:0]   rem_q;
	logic [gdcr_pkg::DIV_NW-1:0]   quo_q;
	logic [gdcr_pkg::DIV_DW-1:0]   den_q;
	logic [gdcr_pkg::DIV_DW:0]     trial;
	logic                          fits;

	assign trial = {rem_q, quo_q[gdcr_pkg::DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(gdcr_pkg::DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= gdcr_pkg::DIV_DW'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[gdcr_pkg::DIV_DW-1:0];
			end
			quo_q <= {quo_q[gdcr_pkg::DIV_NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== hw/rtl/gdcr_front.sv =====
// Front end: accept request words, classify them and queue them for the back end.
module gdcr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  gdcr_pkg::cfg_t  cfg,
	input  logic            hold,
	input  logic            req_valid,
	output logic            req_stall,
	input  gdcr_pkg::req_t  req,
	output logic            q_valid,
	output gdcr_pkg::work_t q_word,
	input  logic            q_pop
);

	gdcr_pkg::work_t         mem_q [gdcr_pkg::QUEUE_DEPTH];
	logic [gdcr_pkg::QW-1:0] wr_ptr_q;
	logic [gdcr_pkg::QW-1:0] rd_ptr_q;
	logic [gdcr_pkg::QW:0]   cnt_q;
	logic                    full;
	logic                    accept;
	logic                    push;
	logic                    do_pop;
	logic [10:0]             width_eff;
	gdcr_pkg::work_t         cls;

	assign full      = cnt_q == (gdcr_pkg::QW+1)'(gdcr_pkg::QUEUE_DEPTH);
	assign req_stall = full || hold;
	assign accept    = req_valid && !req_stall;
	// drop unknown request codes here
	assign push      = accept && (req.req_type != 2'd3);
	assign do_pop    = q_pop && (cnt_q != '0);
	assign width_eff = (cfg.screen_width == '0) ? 11'd1 : cfg.screen_width;

	always_comb begin
		cls        = '0;
		cls.req    = req;
		cls.col_ok = {1'b0, req.column} < width_eff;
		unique case (req.req_type)
			gdcr_pkg::REQ_WRITE: cls.op = gdcr_pkg::OP_WRITE;
			gdcr_pkg::REQ_CLEAR: cls.op = gdcr_pkg::OP_CLEAR;
			default:             cls.op = gdcr_pkg::OP_CAST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= cls;
	end

	assign q_valid = cnt_q != '0;
	assign q_word  = mem_q[rd_ptr_q];

endmodule

// ===== hw/rtl/gdcr_back.sv =====
// Back end: map and depth memories, DDA walk sequencer and result register.
module gdcr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  gdcr_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  gdcr_pkg::work_t q_word,
	output logic            q_pop,
	output logic            init_busy,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output gdcr_pkg::rsp_t  rsp
);

	gdcr_pkg::back_state_t state_q, state_d;

	logic [3:0]  map_mem [gdcr_pkg::MAP_CELLS];
	logic [15:0] depth_mem [gdcr_pkg::MAX_COLUMNS];

	logic [11:0]        cnt_q;
	gdcr_pkg::req_t     wk_q;
	logic signed [15:0] cam_q;
	logic signed [19:0] rx_q, ry_q;
	logic [24:0]        ddx_q, ddy_q;
	logic [33:0]        sdx_q, sdy_q;
	logic signed [7:0]  mx_q, my_q;
	logic               side_q;
	logic [13:0]        addr_q;
	logic               addr_ok_q;
	logic [3:0]         map_rd_q;
	logic [15:0]        dep_rd_q;
	logic [33:0]        perp_q;
	logic [3:0]         cell_q;
	logic [15:0]        lh_q;
	logic [21:0]        frac_q;
	gdcr_pkg::rsp_t     res_q;
	gdcr_pkg::rsp_t     rsp_q;
	logic               rsp_valid_q;

	logic        div_start, div_done;
	logic [24:0] div_num, div_quo;
	logic [33:0] div_den;

	logic        map_we, dep_we;
	logic [11:0] map_waddr;
	logic [3:0]  map_wdata;
	logic [9:0]  dep_waddr;
	logic [15:0] dep_wdata;
	logic        rsp_load;

	logic [10:0]        width_eff;
	logic signed [16:0] ndy, dx17, dy17;
	logic signed [32:0] prod_x, prod_y;
	logic signed [19:0] rx_d, ry_d;
	logic [19:0]        arx, ary;
	logic [8:0]         fx, fy;
	logic [33:0]        sx_prod, sy_prod;
	logic               step_x;
	logic               do_step;
	logic               oob;
	logic [13:0]        addr_d;
	logic [3:0]         tile;
	logic               hit;
	logic [33:0]        perp_d;
	logic [15:0]        dsat;
	logic               nearer;
	logic [8:0]         tw;
	logic [21:0]        ray22;
	logic [7:0]         pcoord;
	logic [43:0]        wall_prod;
	logic [30:0]        tx_prod;
	logic [8:0]         tx_raw, tx_fin;
	logic               mirror;
	logic [3:0]         tn;

	gdcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign width_eff = (cfg.screen_width == '0) ? 11'd1 : cfg.screen_width;

	// ray = dir + plane * camera_x, plane = (-dir_y, dir_x)
	assign dx17   = {wk_q.dir_x[15], wk_q.dir_x};
	assign dy17   = {wk_q.dir_y[15], wk_q.dir_y};
	assign ndy    = -dy17;
	assign prod_x = ndy * cam_q;
	assign prod_y = dx17 * cam_q;
	assign rx_d   = {{4{dx17[16]}}, wk_q.dir_x} + {prod_x[32], prod_x[32:14]};
	assign ry_d   = {{4{dy17[16]}}, wk_q.dir_y} + {prod_y[32], prod_y[32:14]};
	assign arx    = rx_q[19] ? 20'(-rx_q) : 20'(rx_q);
	assign ary    = ry_q[19] ? 20'(-ry_q) : 20'(ry_q);

	assign fx = rx_q[19] ? {1'b0, wk_q.pos_x[7:0]} : 9'd256 - {1'b0, wk_q.pos_x[7:0]};
	assign fy = ry_q[19] ? {1'b0, wk_q.pos_y[7:0]} : 9'd256 - {1'b0, wk_q.pos_y[7:0]};
	assign sx_prod = fx * ddx_q;
	assign sy_prod = fy * ddy_q;

	assign step_x  = sdx_q < sdy_q;
	assign oob     = mx_q[7] || my_q[7] || (mx_q[6:0] >= cfg.map_width)
		|| (my_q[6:0] >= cfg.map_height);
	assign addr_d  = 14'(my_q[6:0] * cfg.map_width) + {7'd0, mx_q[6:0]};
	assign tile    = addr_ok_q ? map_rd_q : 4'd0;
	assign hit     = tile != 4'd0;
	assign do_step = (state_q == gdcr_pkg::BS_STEP) || ((state_q == gdcr_pkg::BS_CHECK) && !hit);
	assign perp_d  = side_q ? sdy_q - {9'd0, ddy_q} : sdx_q - {9'd0, ddx_q};

	assign dsat   = (perp_q[33:16] != '0) ? 16'hFFFF : perp_q[15:0];
	assign nearer = dsat < dep_rd_q;

	assign tw = (cfg.tex_width == '0) ? 9'd1
		: ((cfg.tex_width > 9'd256) ? 9'd256 : cfg.tex_width);
	// only the low 22 bits of the hit coordinate matter
	assign ray22     = side_q ? {{2{rx_q[19]}}, rx_q} : {{2{ry_q[19]}}, ry_q};
	assign pcoord    = side_q ? wk_q.pos_x[7:0] : wk_q.pos_y[7:0];
	assign wall_prod = perp_q[21:0] * ray22;
	assign tx_prod   = frac_q * tw;
	assign tx_raw    = tx_prod[30:22];
	assign mirror    = side_q ? ry_q[19] : (!rx_q[19] && (rx_q != '0));
	assign tx_fin    = mirror ? 9'(tw - tx_raw - 9'd1) : tx_raw;
	assign tn = (cell_q > 4'(gdcr_pkg::NUM_TEXTURES)) ? 4'(gdcr_pkg::NUM_TEXTURES - 1)
		: 4'(cell_q - 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gdcr_pkg::BS_INIT;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		map_we    = 1'b0;
		map_waddr = cnt_q;
		map_wdata = 4'd0;
		dep_we    = 1'b0;
		dep_waddr = cnt_q[9:0];
		dep_wdata = 16'hFFFF;
		rsp_load  = 1'b0;
		unique case (state_q)
			gdcr_pkg::BS_INIT: begin
				map_we = 1'b1;
				dep_we = 1'b1;
				if (cnt_q == '1) state_d = gdcr_pkg::BS_IDLE;
			end
			gdcr_pkg::BS_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_word.op)
						gdcr_pkg::OP_WRITE: begin
							map_we    = 1'b1;
							map_waddr = q_word.req.cell_index;
							map_wdata = q_word.req.cell_value;
						end
						gdcr_pkg::OP_CLEAR: state_d = gdcr_pkg::BS_CLEAR;
						gdcr_pkg::OP_CAST: begin
							if (q_word.col_ok) begin
								div_start = 1'b1;
								div_num   = {q_word.req.column, 15'd0};
								div_den   = {23'd0, width_eff};
								state_d   = gdcr_pkg::BS_CAM;
							end else begin
								state_d = gdcr_pkg::BS_OUT;
							end
						end
						default: state_d = gdcr_pkg::BS_IDLE;
					endcase
				end
			end
			gdcr_pkg::BS_CLEAR: begin
				dep_we = 1'b1;
				if (cnt_q[9:0] == '1) state_d = gdcr_pkg::BS_IDLE;
			end
			gdcr_pkg::BS_CAM: if (div_done) state_d = gdcr_pkg::BS_RAY;
			gdcr_pkg::BS_RAY: state_d = gdcr_pkg::BS_DXS;
			gdcr_pkg::BS_DXS: begin
				if (rx_q == '0) begin
					state_d = gdcr_pkg::BS_DYS;
				end else begin
					div_start = 1'b1;
					div_num   = gdcr_pkg::RECIP_NUM;
					div_den   = {14'd0, arx};
					state_d   = gdcr_pkg::BS_DX;
				end
			end
			gdcr_pkg::BS_DX: if (div_done) state_d = gdcr_pkg::BS_DYS;
			gdcr_pkg::BS_DYS: begin
				if (ry_q == '0) begin
					state_d = gdcr_pkg::BS_SIDE;
				end else begin
					div_start = 1'b1;
					div_num   = gdcr_pkg::RECIP_NUM;
					div_den   = {14'd0, ary};
					state_d   = gdcr_pkg::BS_DY;
				end
			end
			gdcr_pkg::BS_DY: if (div_done) state_d = gdcr_pkg::BS_SIDE;
			gdcr_pkg::BS_SIDE: state_d = gdcr_pkg::BS_STEP;
			gdcr_pkg::BS_STEP: state_d = gdcr_pkg::BS_ADDR;
			gdcr_pkg::BS_ADDR: state_d = oob ? gdcr_pkg::BS_OUT : gdcr_pkg::BS_READ;
			gdcr_pkg::BS_READ: state_d = gdcr_pkg::BS_CHECK;
			gdcr_pkg::BS_CHECK: state_d = hit ? gdcr_pkg::BS_CMP : gdcr_pkg::BS_ADDR;
			gdcr_pkg::BS_CMP: begin
				if (!nearer) begin
					state_d = gdcr_pkg::BS_OUT;
				end else begin
					dep_we    = 1'b1;
					dep_waddr = wk_q.column;
					dep_wdata = dsat;
					if (perp_q == '0) begin
						state_d = gdcr_pkg::BS_TEX1;
					end else begin
						div_start = 1'b1;
						div_num   = {6'd0, cfg.screen_height, 8'd0};
						div_den   = perp_q;
						state_d   = gdcr_pkg::BS_LH;
					end
				end
			end
			gdcr_pkg::BS_LH: if (div_done) state_d = gdcr_pkg::BS_TEX1;
			gdcr_pkg::BS_TEX1: state_d = gdcr_pkg::BS_TEX2;
			gdcr_pkg::BS_TEX2: state_d = gdcr_pkg::BS_OUT;
			gdcr_pkg::BS_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = gdcr_pkg::BS_IDLE;
				end
			end
			default: state_d = gdcr_pkg::BS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= map_wdata;
		map_rd_q <= map_mem[addr_q[11:0]];
	end

	always_ff @(posedge clk) begin
		if (dep_we) depth_mem[dep_waddr] <= dep_wdata;
		dep_rd_q <= depth_mem[wk_q.column];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == gdcr_pkg::BS_INIT) || (state_q == gdcr_pkg::BS_CLEAR)) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) rsp_q <= res_q;
		unique case (state_q)
			gdcr_pkg::BS_IDLE: begin
				if (q_valid && (q_word.op == gdcr_pkg::OP_CAST)) begin
					wk_q             <= q_word.req;
					res_q            <= '0;
					res_q.out_column <= q_word.req.column;
				end
			end
			gdcr_pkg::BS_CAM: if (div_done) cam_q <= 16'(div_quo[15:0] - 16'd16384);
			gdcr_pkg::BS_RAY: begin
				rx_q <= rx_d;
				ry_q <= ry_d;
			end
			gdcr_pkg::BS_DXS: ddx_q <= gdcr_pkg::DELTA_INF;
			gdcr_pkg::BS_DX: if (div_done) ddx_q <= div_quo;
			gdcr_pkg::BS_DYS: ddy_q <= gdcr_pkg::DELTA_INF;
			gdcr_pkg::BS_DY: if (div_done) ddy_q <= div_quo;
			gdcr_pkg::BS_SIDE: begin
				sdx_q <= {8'd0, sx_prod[33:8]};
				sdy_q <= {8'd0, sy_prod[33:8]};
				mx_q  <= {2'b00, wk_q.pos_x[13:8]};
				my_q  <= {2'b00, wk_q.pos_y[13:8]};
			end
			gdcr_pkg::BS_ADDR: begin
				addr_q    <= addr_d;
				addr_ok_q <= addr_d < 14'(gdcr_pkg::MAP_CELLS);
			end
			gdcr_pkg::BS_CHECK: begin
				if (hit) begin
					perp_q <= perp_d;
					cell_q <= tile;
				end
			end
			gdcr_pkg::BS_CMP: lh_q <= 16'hFFFF;
			gdcr_pkg::BS_LH: begin
				if (div_done) lh_q <= (div_quo[24:16] != '0) ? 16'hFFFF : div_quo[15:0];
			end
			gdcr_pkg::BS_TEX1: frac_q <= {pcoord, 14'd0} + wall_prod[21:0];
			gdcr_pkg::BS_TEX2: begin
				res_q.drawn         <= 1'b1;
				res_q.draw_start    <= 16'({5'd0, cfg.screen_height[10:1]} - {1'b0, lh_q[15:1]});
				res_q.line_height   <= lh_q;
				res_q.tex_index     <= tn;
				res_q.tex_column    <= tx_fin[7:0];
				res_q.wall_distance <= dsat;
				res_q.hit_side      <= side_q;
			end
			default: ;
		endcase
		// advance one grid cell along the nearer side distance
		if (do_step) begin
			if (step_x) begin
				sdx_q  <= sdx_q + {9'd0, ddx_q};
				mx_q   <= mx_q + (rx_q[19] ? -8'sd1 : 8'sd1);
				side_q <= 1'b0;
			end else begin
				sdy_q  <= sdy_q + {9'd0, ddy_q};
				my_q   <= my_q + (ry_q[19] ? -8'sd1 : 8'sd1);
				side_q <= 1'b1;
			end
		end
	end

	assign init_busy = state_q == gdcr_pkg::BS_INIT;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/grid_dda_column_raycaster_core.sv =====
// A cast runs up to 4 divides on the shared divider (camera x, both delta distances, line height),
// then the DDA grid walk with a map memory read per step (address, read, check), then setup of
// the result and the texture math.
// Map writes are done straight from the idle state; a depth clear sweeps all 1024 depth entries.
// After reset all 4096 map cells and the depth memory are swept; req_stall stays high meanwhile.
// The front queue holds 2 words, so requests are taken while the back end works.
module grid_dda_column_raycaster_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  gdcr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output gdcr_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [10:0]    cfg_data
);

	gdcr_pkg::cfg_t  cfg_q;
	logic            q_valid;
	logic            q_pop;
	logic            init_busy;
	gdcr_pkg::work_t q_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= 11'd640;
			cfg_q.screen_height <= 11'd480;
			cfg_q.map_width     <= 7'd64;
			cfg_q.map_height    <= 7'd64;
			cfg_q.tex_width     <= 9'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gdcr_pkg::CFG_SCREEN_W: cfg_q.screen_width  <= cfg_data;
				gdcr_pkg::CFG_SCREEN_H: cfg_q.screen_height <= cfg_data;
				gdcr_pkg::CFG_MAP_W:    cfg_q.map_width     <= cfg_data[6:0];
				gdcr_pkg::CFG_MAP_H:    cfg_q.map_height    <= cfg_data[6:0];
				gdcr_pkg::CFG_TEX_W:    cfg_q.tex_width     <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	gdcr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.hold      (init_busy),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_valid   (q_valid),
		.q_word    (q_word),
		.q_pop     (q_pop)
	);

	gdcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_word    (q_word),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== hw/rtl/gdcr_checker.sv =====
// Port-level checks for the ray caster, bound to the top level.
module gdcr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input gdcr_pkg::rsp_t rsp
);

	// hold a stalled result word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.drawn |-> rsp.line_height == '0 && rsp.draw_start == '0
			&& rsp.tex_index == '0 && rsp.tex_column == '0
			&& rsp.wall_distance == '0 && !rsp.hit_side)
		else $error("undrawn result carries geometry");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.drawn |-> rsp.tex_index <= 4'(gdcr_pkg::NUM_TEXTURES - 1))
		else $error("texture index out of range");

	// a drawn slice is strictly nearer than the farthest depth
	a_depth_near: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.drawn |-> rsp.wall_distance != 16'hFFFF)
		else $error("drawn slice at farthest depth");

endmodule

bind grid_dda_column_raycaster_core gdcr_checker u_gdcr_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for the grid DDA column ray caster: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
	import gdcr_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 1500;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [10:0] cfg_data;

	grid_dda_column_raycaster_core u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow state of the caster
	cfg_t shadow_cfg;
	logic [3:0] tile_map [MAP_CELLS];
	logic [15:0] depth_mem [MAX_COLUMNS];
	rsp_t slice_q[$];

	int errors = 0;
	bit idle_en = 1;
	int hold_len = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_sh(longint v, int s);
		longint one;
		one = longint'(1) << s;
		if (v >= 0)
			return v / one;
		return -((-v + one - 1) / one);
	endfunction

	function automatic int tile_at(longint cx, longint cy);
		longint a;
		a = cy * longint'(shadow_cfg.map_width) + cx;
		if (a < 0 || a >= MAP_CELLS)
			return 0;
		return tile_map[a];
	endfunction

	// expected slice for one cast word; updates the depth shadow
	function automatic rsp_t cast_slice(req_t w);
		rsp_t o;
		longint wd, cam, dx, dy, rx, ry, ddx, ddy, sdx, sdy, mx, my, stx, sty;
		longint px, py, perp, wall, frac, lh, dsat, tw, tx, tn;
		int side, hit, steps;
		o = '0;
		o.out_column = w.column;
		side = 0;
		hit = 0;
		wd = shadow_cfg.screen_width == 0 ? 1 : longint'(shadow_cfg.screen_width);
		if (longint'(w.column) >= wd || w.column >= MAX_COLUMNS)
			return o;
		px = w.pos_x;
		py = w.pos_y;
		dx = longint'(w.dir_x);
		dy = longint'(w.dir_y);
		cam = (2 * longint'(w.column) * 16384) / wd - 16384;
		rx = dx + floor_sh(-dy * cam, 14);
		ry = dy + floor_sh(dx * cam, 14);
		ddx = rx == 0 ? 16777216 : 4194304 / (rx < 0 ? -rx : rx);
		ddy = ry == 0 ? 16777216 : 4194304 / (ry < 0 ? -ry : ry);
		mx = px >>> 8;
		my = py >>> 8;
		if (rx < 0) begin
			stx = -1; sdx = floor_sh((px - mx * 256) * ddx, 8);
		end else begin
			stx = 1; sdx = floor_sh(((mx + 1) * 256 - px) * ddx, 8);
		end
		if (ry < 0) begin
			sty = -1; sdy = floor_sh((py - my * 256) * ddy, 8);
		end else begin
			sty = 1; sdy = floor_sh(((my + 1) * 256 - py) * ddy, 8);
		end
		for (steps = 0; steps < 1024 && !hit; steps++) begin
			if (sdx < sdy) begin
				sdx += ddx; mx += stx; side = 0;
			end else begin
				sdy += ddy; my += sty; side = 1;
			end
			if (mx < 0 || mx >= longint'(shadow_cfg.map_width) ||
			    my < 0 || my >= longint'(shadow_cfg.map_height))
				break;
			if (tile_at(mx, my) > 0)
				hit = 1;
		end
		if (!hit)
			return o;
		perp = side == 0 ? sdx - ddx : sdy - ddy;
		if (perp < 0)
			perp = 0;
		dsat = perp > 65535 ? 65535 : perp;
		if (dsat >= longint'(depth_mem[w.column]))
			return o;
		depth_mem[w.column] = dsat[15:0];
		if (perp == 0) begin
			lh = 65535;
		end else begin
			lh = (longint'(shadow_cfg.screen_height) * 256) / perp;
			if (lh > 65535)
				lh = 65535;
		end
		tn = tile_at(mx, my) - 1;
		if (tn > NUM_TEXTURES - 1)
			tn = NUM_TEXTURES - 1;
		tw = shadow_cfg.tex_width == 0 ? 1 :
		     (shadow_cfg.tex_width > 256 ? 256 : longint'(shadow_cfg.tex_width));
		wall = side == 0 ? py * 16384 + perp * ry : px * 16384 + perp * rx;
		frac = wall & 64'h3FFFFF;
		tx = (frac * tw) >>> 22;
		if ((side == 0 && rx > 0) || (side == 1 && ry < 0))
			tx = tw - tx - 1;
		o.drawn = 1'b1;
		o.draw_start = 16'(longint'(shadow_cfg.screen_height / 2) - lh / 2);
		o.line_height = lh[15:0];
		o.tex_index = tn[3:0];
		o.tex_column = tx[7:0];
		o.wall_distance = dsat[15:0];
		o.hit_side = side[0];
		return o;
	endfunction

	// apply one accepted word to the shadow and queue its slice if any
	task automatic apply_word(req_t w, bit typed, rsp_t typed_slice);
		rsp_t e;
		case (w.req_type)
		REQ_WRITE: tile_map[w.cell_index] = w.cell_value;
		REQ_CLEAR: foreach (depth_mem[i]) depth_mem[i] = 16'hFFFF;
		REQ_CAST: begin
			e = cast_slice(w);
			slice_q.push_back(typed ? typed_slice : e);
		end
		default: ;
		endcase
	endtask

	task automatic send_word(req_t w, bit typed = 0, rsp_t typed_slice = '0);
		int gap;
		gap = idle_en ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		apply_word(w, typed, typed_slice);
	endtask

	// drop valid and wait until every slice is back and the back end has settled
	task automatic drain;
		req_valid <= 1'b0;
		@(posedge clk);
		while (slice_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [10:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
		CFG_SCREEN_W: shadow_cfg.screen_width = val;
		CFG_SCREEN_H: shadow_cfg.screen_height = val;
		CFG_MAP_W: shadow_cfg.map_width = val[6:0];
		CFG_MAP_H: shadow_cfg.map_height = val[6:0];
		CFG_TEX_W: shadow_cfg.tex_width = val[8:0];
		default: ;
		endcase
	endtask

	task automatic set_config(int sw, int sh, int mw, int mh, int tw);
		write_reg(CFG_SCREEN_W, 11'(sw));
		write_reg(CFG_SCREEN_H, 11'(sh));
		write_reg(CFG_MAP_W, 11'(mw));
		write_reg(CFG_MAP_H, 11'(mh));
		write_reg(CFG_TEX_W, 11'(tw));
	endtask

	function automatic req_t mk_word(logic [1:0] t, int col, int px, int py, int dx, int dy,
	                                 int idx, int val);
		req_t w;
		w.req_type = t;
		w.column = 10'(col);
		w.pos_x = 14'(px);
		w.pos_y = 14'(py);
		w.dir_x = 16'(dx);
		w.dir_y = 16'(dy);
		w.cell_index = 12'(idx);
		w.cell_value = 4'(val);
		return w;
	endfunction

	function automatic rsp_t blank_slice(int col);
		rsp_t o;
		o = '0;
		o.out_column = 10'(col);
		return o;
	endfunction

	// directed table at reset settings (640x480, 64x64 map, 64 texels)
	typedef struct {
		req_t word;
		bit   typed;
		rsp_t slice;
	} row_t;
	row_t dir_rows[$];

	task automatic add_row(req_t w, bit typed = 0, rsp_t s = '0);
		row_t r;
		r.word = w;
		r.typed = typed;
		r.slice = s;
		dir_rows.push_back(r);
	endtask

	task automatic run_directed;
		int mid;
		mid = 32 * 256 + 128;
		// empty map: every ray leaves
		add_row(mk_word(REQ_CAST, 320, mid, mid, 16384, 0, 0, 0), 1, blank_slice(320));
		add_row(mk_word(REQ_CAST, 700, mid, mid, 16384, 0, 0, 0), 1, blank_slice(700));
		add_row(mk_word(REQ_CAST, 1023, 0, 16383, 0, -16384, 0, 0), 1, blank_slice(1023));
		add_row(mk_word(REQ_NONE, 5, mid, mid, 16384, 0, 100, 3));
		add_row(mk_word(REQ_WRITE, 0, 0, 0, 0, 0, 32 * 64 + 40, 15));
		add_row(mk_word(REQ_WRITE, 0, 0, 0, 0, 0, 32 * 64 + 20, 10));
		add_row(mk_word(REQ_WRITE, 0, 0, 0, 0, 0, 40 * 64 + 32, 1));
		add_row(mk_word(REQ_WRITE, 0, 0, 0, 0, 0, 20 * 64 + 32, 8));
		add_row(mk_word(REQ_WRITE, 0, 0, 0, 0, 0, 4095, 7));
		add_row(mk_word(REQ_CAST, 320, mid, mid, 16384, 0, 0, 0));
		// same ray again is not nearer
		add_row(mk_word(REQ_CAST, 320, mid, mid, 16384, 0, 0, 0), 1, blank_slice(320));
		add_row(mk_word(REQ_CAST, 321, mid, mid, -16384, 0, 0, 0));
		add_row(mk_word(REQ_CAST, 322, mid, mid, 0, 16384, 0, 0));
		add_row(mk_word(REQ_CAST, 0, mid, mid, 0, -16384, 0, 0));
		add_row(mk_word(REQ_CAST, 639, mid, mid, 11585, 11585, 0, 0));
		add_row(mk_word(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		// standing on the wall edge: zero distance, height saturates
		add_row(mk_word(REQ_CAST, 320, 41 * 256, mid, -16384, 0, 0, 0));
		add_row(mk_word(REQ_CAST, 100, 16383, 16383, -16384, -16384, 0, 0));
		add_row(mk_word(REQ_CAST, 101, 0, 0, 16384, 16384, 0, 0));
		add_row(mk_word(REQ_CAST, 639, 16383, 0, -32768 + 16384, 16384, 0, 0));
		add_row(mk_word(REQ_WRITE, 0, 0, 0, 0, 0, 4095, 0));
		add_row(mk_word(REQ_CAST, 5, 63 * 256 + 10, 63 * 256 + 10, 0, 16384, 0, 0));
		foreach (dir_rows[i])
			send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].slice);
		drain();
	endtask

	task automatic run_phase(int sw, int sh, int mw, int mh, int tw, int n, int hold);
		int roll, cx, cy, cw, ncols;
		req_t w;
		set_config(sw, sh, mw, mh, tw);
		idle_en = $urandom_range(0, 3) != 0;
		// wall ring so that most rays hit
		for (int y = 0; y < mh && y < 64; y++)
			for (int x = 0; x < mw && x < 64; x++)
				if (x == 0 || y == 0 || x == mw - 1 || y == mh - 1)
					send_word(mk_word(REQ_WRITE, 0, 0, 0, 0, 0, y * mw + x,
					                  $urandom_range(1, 10)));
		send_word(mk_word(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		hold_len = hold;
		ncols = sw == 0 ? 1 : (sw > 1024 ? 1024 : sw);
		cw = mw == 0 ? 1 : mw;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			w = req_t'({$urandom, $urandom, $urandom});
			if (roll < 62) begin
				w.req_type = REQ_CAST;
				w.column = roll < 58 ? 10'($urandom_range(0, ncols - 1)) : w.column;
				w.pos_x = 14'($urandom_range(0, (cw > 64 ? 64 : cw) * 256 - 1));
				w.pos_y = 14'($urandom_range(0, (mh == 0 ? 1 : (mh > 64 ? 64 : mh)) * 256 - 1));
				w.dir_x = 16'($urandom_range(0, 32768) - 16384);
				w.dir_y = 16'($urandom_range(0, 32768) - 16384);
			end else if (roll < 80) begin
				cx = $urandom_range(0, cw - 1);
				cy = $urandom_range(0, 63);
				w.req_type = REQ_WRITE;
				w.cell_index = roll < 76 ? 12'(cy * cw + cx) : w.cell_index;
				w.cell_value = $urandom_range(0, 2) == 0 ? 4'd0 : 4'($urandom_range(1, 10));
			end else if (roll < 90) begin
				w.req_type = REQ_CLEAR;
			end else if (roll < 97) begin
				w.req_type = REQ_CAST;
				w.dir_x = 16'($urandom_range(0, 32768) - 16384);
				w.dir_y = 16'($urandom_range(0, 32768) - 16384);
			end else begin
				w.req_type = REQ_NONE;
			end
			send_word(w);
		end
		drain();
	endtask

	// result side: check, then pick the stall for the next cycle
	initial begin
		int stall_left;
		rsp_t e;
		stall_left = 0;
		rsp_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				if (slice_q.size() == 0) begin
					$display("%0t: unexpected slice %p", $time, rsp);
					errors++;
				end else begin
					e = slice_q.pop_front();
					if (rsp !== e) begin
						$display("%0t: slice mismatch exp %p act %p", $time, e, rsp);
						errors++;
					end
				end
				stall_left = idle_en ? $urandom_range(0, 3) : 0;
			end
			if (hold_len > 0) begin
				hold_len--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
			    (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		shadow_cfg.screen_width = 640;
		shadow_cfg.screen_height = 480;
		shadow_cfg.map_width = 64;
		shadow_cfg.map_height = 64;
		shadow_cfg.tex_width = 64;
		foreach (tile_map[i]) tile_map[i] = '0;
		foreach (depth_mem[i]) depth_mem[i] = 16'hFFFF;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_phase(640, 480, 16, 16, 64, 120, 0);
		run_phase(1, 1, 1, 1, 1, 40, 0);
		run_phase(1024, 1024, 64, 64, 256, 80, 800);
		run_phase(320, 200, 12, 9, 100, 140, 0);
		run_phase(0, 2047, 8, 8, 0, 60, 0);
		run_phase(1024, 7, 5, 20, 511, 100, 0);
		run_phase(200, 600, 100, 100, 33, 40, 0);
		run_phase(64, 480, 16, 16, 256, 140, 600);
		run_phase(640, 480, 64, 64, 64, 80, 0);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
